[hw/rtl/pfcrc_pkg.sv]
// package for the page frame crc16 builder
// request and response payload types, sequencer phases and the crc-16/arc byte step
// no dependencies
`default_nettype none

package pfcrc_pkg;

   localparam int DATA_BYTES_DEFAULT = 64;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'h0000;

   typedef struct packed {
      logic [7:0] page_number;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       is_checksum;
      logic       frame_end;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_PAGE,
      PH_DATA,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   // reflected crc update over one byte, lsb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/page_frame_crc16_builder.sv]
// page frame crc16 builder top level: frame sequencer, crc accumulator, response register
// depends on pfcrc_pkg
`default_nettype none

// Takes one page data byte per request and emits the transmit frame: the page number
// ahead of a frame's first data byte, each data byte, and after DATA_BYTES data bytes
// the CRC-16/ARC (poly 0xA001 reflected, init 0) low byte then high byte, the high
// byte marked frame_end. A frame is DATA_BYTES + 3 bytes. The CRC over page number and
// data byte is computed when the request is taken and parked with it in a one-entry
// item register; a response register then sends its bytes one per cycle unless rsp_stall
// holds it. A new request is taken in the cycle its predecessor's last byte moves to the
// response register, so throughput is one output byte per cycle while not stalled: a
// mid-frame request makes one byte, a frame's first two, its last three (four when
// DATA_BYTES is 1), each passing the item register and then the response register.
module page_frame_crc16_builder #(
   parameter int DATA_BYTES = pfcrc_pkg::DATA_BYTES_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire pfcrc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output pfcrc_pkg::rsp_type rsp_data
);

   // a page size of zero behaves as one byte per frame
   localparam int FRAME_BYTES = (DATA_BYTES < 1) ? 1 : DATA_BYTES;
   localparam int POS_W = (FRAME_BYTES > 2) ? $clog2(FRAME_BYTES) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

   // frame position and running crc
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;

   // item register
   logic                 item_valid_ff, item_valid_in;
   pfcrc_pkg::phase_type phase_ff, phase_in;
   logic [7:0]           item_page_ff, item_page_in;
   logic [7:0]           item_byte_ff, item_byte_in;
   logic [15:0]          item_crc_ff, item_crc_in;
   logic                 item_last_ff, item_last_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   pfcrc_pkg::rsp_type rsp_ff, rsp_in;

   logic                 req_take;
   logic                 rsp_load;
   logic                 item_done;
   pfcrc_pkg::phase_type phase_next;
   pfcrc_pkg::rsp_type   item_out;
   logic                 frame_first;
   logic                 frame_last;
   logic [15:0]          crc_start;
   logic [15:0]          crc_new;

   assign rsp_load  = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !(rsp_load && item_done);
   assign req_take  = req_valid && !req_stall;

   assign frame_first = (pos_ff == '0);
   assign frame_last  = (pos_ff == POS_LAST);
   assign crc_start   = frame_first ? pfcrc_pkg::crc_byte(pfcrc_pkg::CRC_INIT,
                                                          req_data.page_number) : crc_ff;
   assign crc_new     = pfcrc_pkg::crc_byte(crc_start, req_data.data_byte);

   // next phase of the item being sent
   always_comb begin
      phase_next = phase_ff;
      item_done  = 1'b0;
      case (phase_ff)
         pfcrc_pkg::PH_PAGE: begin
            phase_next = pfcrc_pkg::PH_DATA;
         end
         pfcrc_pkg::PH_DATA: begin
            if (item_last_ff) begin
               phase_next = pfcrc_pkg::PH_CRC_LO;
            end else begin
               item_done = 1'b1;
            end
         end
         pfcrc_pkg::PH_CRC_LO: begin
            phase_next = pfcrc_pkg::PH_CRC_HI;
         end
         pfcrc_pkg::PH_CRC_HI: begin
            item_done = 1'b1;
         end
         default: begin
            item_done = 1'b1;
         end
      endcase
   end

   // byte for the current phase
   always_comb begin
      item_out = '0;
      case (phase_ff)
         pfcrc_pkg::PH_PAGE: begin
            item_out.frame_byte = item_page_ff;
         end
         pfcrc_pkg::PH_DATA: begin
            item_out.frame_byte = item_byte_ff;
         end
         pfcrc_pkg::PH_CRC_LO: begin
            item_out.frame_byte  = item_crc_ff[7:0];
            item_out.is_checksum = 1'b1;
         end
         pfcrc_pkg::PH_CRC_HI: begin
            item_out.frame_byte  = item_crc_ff[15:8];
            item_out.is_checksum = 1'b1;
            item_out.frame_end   = 1'b1;
         end
         default: begin
            item_out = '0;
         end
      endcase
   end

   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      item_valid_in = item_valid_ff;
      phase_in      = phase_ff;
      item_page_in  = item_page_ff;
      item_byte_in  = item_byte_ff;
      item_crc_in   = item_crc_ff;
      item_last_in  = item_last_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;

      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = item_valid_ff;
         rsp_in       = item_out;
      end

      if (rsp_load) begin
         if (item_done) begin
            item_valid_in = 1'b0;
         end else begin
            phase_in = phase_next;
         end
      end

      if (req_take) begin
         item_valid_in = 1'b1;
         phase_in      = frame_first ? pfcrc_pkg::PH_PAGE : pfcrc_pkg::PH_DATA;
         item_page_in  = req_data.page_number;
         item_byte_in  = req_data.data_byte;
         item_crc_in   = crc_new;
         item_last_in  = frame_last;
         if (frame_last) begin
            pos_in = '0;
            crc_in = pfcrc_pkg::CRC_INIT;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            crc_in = crc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         crc_ff        <= pfcrc_pkg::CRC_INIT;
         item_valid_ff <= 1'b0;
         phase_ff      <= pfcrc_pkg::PH_PAGE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_page_ff <= item_page_in;
      item_byte_ff <= item_byte_in;
      item_crc_ff  <= item_crc_in;
      item_last_ff <= item_last_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // frame end only ever marks a crc byte
   a_end_is_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.is_checksum)
      else $error("frame_end on a non-crc byte");

   // crc phases belong only to a frame's last request
   a_crc_phase_last: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && (phase_ff == pfcrc_pkg::PH_CRC_LO || phase_ff == pfcrc_pkg::PH_CRC_HI)
      |-> item_last_ff)
      else $error("crc phase on a request that does not close its frame");

   // at a frame start the accumulator is back at its initial value
   a_crc_cleared: assert property (@(posedge clock)
      pos_ff == '0 |-> crc_ff == pfcrc_pkg::CRC_INIT)
      else $error("crc not cleared at frame start");

   // a stalled response with a pending item keeps the item parked
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && rsp_valid_ff && rsp_stall |=> item_valid_ff && $stable(phase_ff))
      else $error("item advanced while response stalled");

endmodule

`default_nettype wire
